@@ src/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, codes and constants shared by the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CHAIN_N    = 5;
  localparam int unsigned WIN_N      = 16;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned COUNT_W    = 64;

  localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
  localparam logic [ROUND_W-1:0] SCHED_ROUND = 7'd16;
  localparam logic [FILL_W-1:0]  LAST_FILL   = 6'd63;
  localparam logic [FILL_W-1:0]  LEN_FILL    = 6'd56;
  localparam logic [7:0]         PAD_BYTE    = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [CHAIN_N] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [WORD_W-1:0] K_ROUND [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word_0;
    logic [WORD_W-1:0] digest_word_1;
    logic [WORD_W-1:0] digest_word_2;
    logic [WORD_W-1:0] digest_word_3;
    logic [WORD_W-1:0] digest_word_4;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_t;

  typedef struct packed {
    logic               byte_en;
    logic               word_en;
    logic [7:0]         byte_val;
    logic               rnd_init;
    logic               rnd_en;
    logic [ROUND_W-1:0] round_idx;
    logic               fold;
    logic               chain_init;
    logic               out_load;
  } ctl_t;

endpackage

@@ src/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// sha1md_sched
// Byte packer and 16-word message schedule shift register.
// ----------------------------------------------------------------------------
module sha1md_sched
  import sha1md_pkg::*;
(
  input  logic              clk,
  input  ctl_t              ctl,
  output logic [WORD_W-1:0] w_t
);

  logic [23:0]       wacc_r;
  logic [WORD_W-1:0] win_r [WIN_N];
  logic [WORD_W-1:0] mix;

  assign mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_t = (ctl.round_idx < SCHED_ROUND) ? win_r[0] : {mix[WORD_W-2:0], mix[WORD_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      wacc_r <= {wacc_r[15:0], ctl.byte_val};
    end
    if (ctl.word_en || ctl.rnd_en) begin
      for (int i = 0; i < WIN_N - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_N-1] <= ctl.word_en ? {wacc_r, ctl.byte_val} : w_t;
    end
  end

endmodule

@@ src/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round per cycle on the working variables, and the chain words.
// ----------------------------------------------------------------------------
module sha1md_round
  import sha1md_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic [WORD_W-1:0] w_t,
  output logic [WORD_W-1:0] chain [CHAIN_N]
);

  logic [WORD_W-1:0] var_r [CHAIN_N];
  logic [WORD_W-1:0] chain_r [CHAIN_N];
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] k_val;
  logic [WORD_W-1:0] tmp;
  logic [WORD_W-1:0] a_rot;
  logic [WORD_W-1:0] b_rot;

  always_comb begin
    if (ctl.round_idx < 7'd20) begin
      f_val = (var_r[1] & var_r[2]) | (~var_r[1] & var_r[3]);
      k_val = K_ROUND[0];
    end else if (ctl.round_idx < 7'd40) begin
      f_val = var_r[1] ^ var_r[2] ^ var_r[3];
      k_val = K_ROUND[1];
    end else if (ctl.round_idx < 7'd60) begin
      f_val = (var_r[1] & var_r[2]) | (var_r[1] & var_r[3]) | (var_r[2] & var_r[3]);
      k_val = K_ROUND[2];
    end else begin
      f_val = var_r[1] ^ var_r[2] ^ var_r[3];
      k_val = K_ROUND[3];
    end
  end

  assign a_rot = {var_r[0][WORD_W-6:0], var_r[0][WORD_W-1:WORD_W-5]};
  assign b_rot = {var_r[1][1:0], var_r[1][WORD_W-1:2]};
  assign tmp   = a_rot + f_val + var_r[4] + k_val + w_t;
  assign chain = chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= H_INIT[i];
        var_r[i]   <= '0;
      end
    end else begin
      if (ctl.rnd_init) begin
        var_r <= chain_r;
      end else if (ctl.rnd_en) begin
        var_r[0] <= tmp;
        var_r[1] <= var_r[0];
        var_r[2] <= b_rot;
        var_r[3] <= var_r[2];
        var_r[4] <= var_r[3];
      end
      if (ctl.fold) begin
        for (int i = 0; i < CHAIN_N; i++) begin
          chain_r[i] <= chain_r[i] + var_r[i];
        end
      end else if (ctl.chain_init) begin
        for (int i = 0; i < CHAIN_N; i++) begin
          chain_r[i] <= H_INIT[i];
        end
      end
    end
  end

endmodule

@@ src/sha1md_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: byte intake, padding, round count and result handshake.
// ----------------------------------------------------------------------------
module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output ctl_t    ctl
);

  state_t              state_r, state_nxt;
  pad_t                pad_r, pad_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ROUND_W-1:0]  round_r, round_nxt;
  logic [2:0]          len_idx_r, len_idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pad_r       <= PH_NONE;
      fill_r      <= '0;
      count_r     <= '0;
      round_r     <= '0;
      len_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pad_r       <= pad_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      len_idx_r   <= len_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    fill_nxt    = fill_r;
    count_nxt   = count_r;
    round_nxt   = round_r;
    len_idx_nxt = len_idx_r;
    ctl         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_valid) begin
            ctl.byte_en  = 1'b1;
            ctl.byte_val = in_data.data_byte;
            count_nxt    = count_r + 64'd8;
          end
          if (in_data.end_of_message) begin
            pad_nxt     = PH_MARK;
            len_idx_nxt = 3'd7;
            state_nxt   = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        case (pad_r)
          PH_MARK: begin
            ctl.byte_en  = 1'b1;
            ctl.byte_val = PAD_BYTE;
            pad_nxt      = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == LEN_FILL) begin
              pad_nxt = PH_LEN;
            end else begin
              ctl.byte_en = 1'b1;
            end
          end
          PH_LEN: begin
            ctl.byte_en  = 1'b1;
            ctl.byte_val = count_r[{len_idx_r, 3'b000} +: 8];
            len_idx_nxt  = len_idx_r - 3'd1;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ROUND: begin
        ctl.rnd_en    = 1'b1;
        ctl.round_idx = round_r;
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = ST_FOLD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (pad_r == PH_LEN) begin
          state_nxt = ST_DONE;
        end else if (pad_r != PH_NONE) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_load   = 1'b1;
          ctl.chain_init = 1'b1;
          count_nxt      = '0;
          pad_nxt        = PH_NONE;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ctl.byte_en) begin
      ctl.word_en = (fill_r[1:0] == 2'b11);
      fill_nxt    = fill_r + 6'd1;
      if (fill_r == LAST_FILL) begin
        ctl.rnd_init = 1'b1;
        state_nxt    = ST_ROUND;
      end
    end

    out_valid_nxt = ctl.out_load | (out_valid_r & out_stall);
  end

  a_round_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (fill_r == '0))
    else $error("compression running with partial block");

  a_last_round_folds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == LAST_ROUND) |=> (state_r == ST_FOLD))
    else $error("last round not followed by fold");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_idle_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pad_r == PH_NONE))
    else $error("padding pending while idle");

  a_len_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD && pad_r == PH_LEN && len_idx_r == 3'd0) |=> (state_r == ST_ROUND))
    else $error("length bytes did not close a block");

endmodule

@@ src/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream.
//
// Input requests carry one message byte (data_byte, qualified by
// byte_valid) and an end_of_message flag; a request with byte_valid low
// and end_of_message high closes the message without a byte. A request
// is taken when in_valid is high and in_stall is low. The 64th byte of a
// block starts the compression, which runs the rounds on one round unit
// and then folds into the chain words, with in_stall high throughout, so
// no new byte is taken until the block is done. An end request feeds
// padding through the byte path, running one or two more compressions
// before the digest request appears on out_data with out_valid; it waits
// while a previous digest is still held under out_stall.
// The digest sits in an output register; new bytes are taken while it
// waits under out_stall, and only the next digest waits for it to drain.
// After the digest the chain returns to the initial values. Reset returns
// the chain to them and clears the bit count and the pending result.
// ----------------------------------------------------------------------------
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  ctl_t              ctl;
  logic [WORD_W-1:0] w_t;
  logic [WORD_W-1:0] chain [CHAIN_N];
  out_req_t          out_data_r;

  sha1md_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  sha1md_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w_t (w_t)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w_t   (w_t),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.digest_word_0 <= chain[0];
      out_data_r.digest_word_1 <= chain[1];
      out_data_r.digest_word_2 <= chain[2];
      out_data_r.digest_word_3 <= chain[3];
      out_data_r.digest_word_4 <= chain[4];
    end
  end

  assign out_data = out_data_r;

endmodule
